// ===== design/pta_pkg.sv =====
package pta_pkg;

	// Capacity of each term store.
	localparam int MAX_TERMS = 16;

	// Width of a term count (0 .. MAX_TERMS) and of a store index.
	localparam int CNT_W = $clog2(MAX_TERMS + 1);
	localparam int IDX_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;

	// Each store memory holds the loaded terms in its lower half and the
	// sorted copy in its upper half.
	localparam int ADDR_W    = IDX_W + 1;
	localparam int MEM_DEPTH = 2 ** ADDR_W;

	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_TERMS);

	localparam int COEF_W = 32;
	localparam int EXPO_W = 16;
	localparam int SUM_W  = COEF_W + 1;

	// Input item modes.
	localparam logic [1:0] MODE_LOAD_FIRST  = 2'd0;
	localparam logic [1:0] MODE_LOAD_SECOND = 2'd1;
	localparam logic [1:0] MODE_RUN         = 2'd2;

	typedef struct packed {
		logic signed [COEF_W-1:0] coef;
		logic signed [EXPO_W-1:0] expo;
	} term_t;

	typedef struct packed {
		logic             load;
		logic             sort_start;
		logic             clear;
		logic [IDX_W-1:0] rd_idx;
	} store_ctrl_t;

	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic             sort_busy;
	} store_stat_t;

	typedef struct packed {
		logic signed [SUM_W-1:0]  sum_coefficient;
		logic signed [EXPO_W-1:0] sum_exponent;
		logic                     term_valid;
		logic                     last_term;
		logic                     overflow;
	} result_t;

endpackage

// ===== design/pta_in_if.sv =====
interface pta_in_if;
	logic                                   valid;
	logic                                   ready;
	logic [1:0]                             mode;
	logic signed [pta_pkg::COEF_W-1:0]      coefficient;
	logic signed [pta_pkg::EXPO_W-1:0]      exponent;

	modport source (output valid, output mode, output coefficient, output exponent,
		input ready);
	modport sink (input valid, input mode, input coefficient, input exponent,
		output ready);
endinterface

// ===== design/pta_out_if.sv =====
interface pta_out_if;
	logic                                   valid;
	logic                                   ready;
	logic signed [pta_pkg::SUM_W-1:0]       sum_coefficient;
	logic signed [pta_pkg::EXPO_W-1:0]      sum_exponent;
	logic                                   term_valid;
	logic                                   last_term;
	logic                                   overflow;

	modport source (output valid, output sum_coefficient, output sum_exponent,
		output term_valid, output last_term, output overflow, input ready);
	modport sink (input valid, input sum_coefficient, input sum_exponent,
		input term_valid, input last_term, input overflow, output ready);
endinterface

// ===== design/polynomial_term_merge_add_unit.sv =====
// A load item is taken while the block is idle, and another item can follow right behind it.
// A run item first ranks both stores in parallel, key by key, then merges through the
// T_ISSUE and T_DEC states, at most one result item per merge step, and then sends the
// final item of the run from T_FLUSH once the output register is free.
// Throughput is set by the single read port of each store memory during sort and merge.
// Reset clears the counts, the drop flag and all control; store memories are not cleared.
module polynomial_term_merge_add_unit (
	input  logic             clk,
	input  logic             arst_n,
	pta_in_if.sink           term,
	pta_out_if.source        result
);
	localparam int CW = pta_pkg::CNT_W;
	localparam int IW = pta_pkg::IDX_W;
	localparam int SW = pta_pkg::SUM_W;
	localparam int EW = pta_pkg::EXPO_W;

	// T_SORT waits for both sorters, T_ISSUE presents the merge indexes to the
	// memories, T_DEC sees the read data and takes one merge step, and T_FLUSH
	// sends the final item of the run.
	typedef enum logic [2:0] {T_IDLE, T_SORT, T_ISSUE, T_DEC, T_FLUSH} top_state_t;

	top_state_t            state_q;
	logic                  dropped_q;
	logic [CW-1:0]         i_q;
	logic [CW-1:0]         j_q;
	logic                  pend_v_q;
	logic signed [SW-1:0]  pend_coef_q;
	logic signed [EW-1:0]  pend_expo_q;
	logic                  out_v_q;
	pta_pkg::result_t      out_q;

	pta_pkg::store_ctrl_t  ctrl_a;
	pta_pkg::store_ctrl_t  ctrl_b;
	pta_pkg::store_stat_t  stat_a;
	pta_pkg::store_stat_t  stat_b;
	pta_pkg::term_t        rd_a;
	pta_pkg::term_t        rd_b;
	pta_pkg::term_t        load_term;

	logic                  accept;
	logic                  is_load_a;
	logic                  is_load_b;
	logic                  is_run;
	logic                  slot_free;
	logic                  a_av;
	logic                  b_av;
	logic                  take_a;
	logic                  take_b;
	logic                  emit_new;
	logic                  step_ok;
	logic                  merge_done;
	logic                  flush_push;
	logic                  out_push;
	logic signed [SW-1:0]  pair_sum;
	logic signed [SW-1:0]  new_coef;
	logic signed [EW-1:0]  new_expo;

	// Input side. Items are taken only between runs; a store that is full
	// drops the term and raises the drop flag instead.
	assign term.ready = (state_q == T_IDLE);
	assign accept     = term.valid && term.ready;
	assign is_load_a  = accept && (term.mode == pta_pkg::MODE_LOAD_FIRST);
	assign is_load_b  = accept && (term.mode == pta_pkg::MODE_LOAD_SECOND);
	assign is_run     = accept && (term.mode == pta_pkg::MODE_RUN);

	assign load_term.coef = term.coefficient;
	assign load_term.expo = term.exponent;

	// The output register is free when empty or when its item leaves now.
	assign slot_free  = !out_v_q || result.ready;
	assign flush_push = (state_q == T_FLUSH) && slot_free;

	// The output register is loaded by a merge step that pushes out the held
	// term, or by the final item of the run.
	assign out_push = flush_push ||
		((state_q == T_DEC) && !merge_done && step_ok && emit_new && pend_v_q);

	always_comb begin
		ctrl_a.load       = is_load_a && (stat_a.count != pta_pkg::CNT_FULL);
		ctrl_a.sort_start = is_run;
		ctrl_a.clear      = flush_push;
		ctrl_a.rd_idx     = i_q[IW-1:0];
		ctrl_b.load       = is_load_b && (stat_b.count != pta_pkg::CNT_FULL);
		ctrl_b.sort_start = is_run;
		ctrl_b.clear      = flush_push;
		ctrl_b.rd_idx     = j_q[IW-1:0];
	end

	pta_term_store u_store_a (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl_a),
		.load_term (load_term),
		.stat      (stat_a),
		.rd_term   (rd_a)
	);

	pta_term_store u_store_b (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl_b),
		.load_term (load_term),
		.stat      (stat_b),
		.rd_term   (rd_b)
	);

	// One merge step. Equal exponents combine and a zero sum emits nothing;
	// otherwise the smaller exponent goes first, and an exhausted side lets
	// the other side copy through.
	always_comb begin
		a_av       = i_q < stat_a.count;
		b_av       = j_q < stat_b.count;
		merge_done = !a_av && !b_av;
		pair_sum   = SW'(rd_a.coef) + SW'(rd_b.coef);
		take_a     = 1'b0;
		take_b     = 1'b0;
		new_coef   = '0;
		new_expo   = '0;
		emit_new   = 1'b0;
		if (a_av && b_av && (rd_a.expo == rd_b.expo)) begin
			take_a   = 1'b1;
			take_b   = 1'b1;
			new_coef = pair_sum;
			new_expo = rd_a.expo;
			emit_new = (pair_sum != '0);
		end else if (a_av && (!b_av || ($signed(rd_a.expo) < $signed(rd_b.expo)))) begin
			take_a   = 1'b1;
			new_coef = SW'(rd_a.coef);
			new_expo = rd_a.expo;
			emit_new = 1'b1;
		end else if (b_av) begin
			take_b   = 1'b1;
			new_coef = SW'(rd_b.coef);
			new_expo = rd_b.expo;
			emit_new = 1'b1;
		end
		// A new term pushes the held one out, which needs the output register.
		step_ok = !emit_new || !pend_v_q || slot_free;
	end

	// The most recent term is held back one step so that the last one can be
	// marked once the merge is known to have ended.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= T_IDLE;
			dropped_q   <= 1'b0;
			i_q         <= '0;
			j_q         <= '0;
			pend_v_q    <= 1'b0;
			pend_coef_q <= '0;
			pend_expo_q <= '0;
			out_v_q     <= 1'b0;
			out_q       <= '0;
		end else begin
			if (out_push) begin
				out_v_q <= 1'b1;
			end else if (result.ready) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				T_IDLE: begin
					if ((is_load_a && (stat_a.count == pta_pkg::CNT_FULL)) ||
						(is_load_b && (stat_b.count == pta_pkg::CNT_FULL))) begin
						dropped_q <= 1'b1;
					end
					if (is_run) begin
						i_q     <= '0;
						j_q     <= '0;
						state_q <= T_SORT;
					end
				end
				T_SORT: begin
					if (!stat_a.sort_busy && !stat_b.sort_busy) begin
						state_q <= T_ISSUE;
					end
				end
				T_ISSUE: begin
					state_q <= T_DEC;
				end
				T_DEC: begin
					if (merge_done) begin
						state_q <= T_FLUSH;
					end else if (step_ok) begin
						if (take_a) begin
							i_q <= i_q + 1'b1;
						end
						if (take_b) begin
							j_q <= j_q + 1'b1;
						end
						if (emit_new) begin
							if (pend_v_q) begin
								out_q.sum_coefficient <= pend_coef_q;
								out_q.sum_exponent    <= pend_expo_q;
								out_q.term_valid      <= 1'b1;
								out_q.last_term       <= 1'b0;
								out_q.overflow        <= dropped_q;
							end
							pend_v_q    <= 1'b1;
							pend_coef_q <= new_coef;
							pend_expo_q <= new_expo;
						end
						state_q <= T_ISSUE;
					end
				end
				T_FLUSH: begin
					if (slot_free) begin
						out_q.last_term  <= 1'b1;
						out_q.overflow   <= dropped_q;
						out_q.term_valid <= pend_v_q;
						if (pend_v_q) begin
							out_q.sum_coefficient <= pend_coef_q;
							out_q.sum_exponent    <= pend_expo_q;
						end else begin
							// Everything cancelled or both stores were empty.
							out_q.sum_coefficient <= '0;
							out_q.sum_exponent    <= '0;
						end
						pend_v_q  <= 1'b0;
						dropped_q <= 1'b0;
						i_q       <= '0;
						j_q       <= '0;
						state_q   <= T_IDLE;
					end
				end
				default: begin
					state_q <= T_IDLE;
				end
			endcase
		end
	end

	assign result.valid           = out_v_q;
	assign result.sum_coefficient = out_q.sum_coefficient;
	assign result.sum_exponent    = out_q.sum_exponent;
	assign result.term_valid      = out_q.term_valid;
	assign result.last_term       = out_q.last_term;
	assign result.overflow        = out_q.overflow;

	// Only the final item of a run may carry no term.
	a_empty_only_last: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.last_term |-> result.term_valid)
		else $error("result without a term before the end of the run");

	// Merging starts only after both stores are sorted.
	a_sorted_before_merge: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == T_ISSUE) |-> (!stat_a.sort_busy && !stat_b.sort_busy))
		else $error("merge read while a store is still sorting");

	// The merge never walks past the stored terms.
	a_index_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(i_q <= stat_a.count) && (j_q <= stat_b.count))
		else $error("merge index beyond store count");

	// The end of a run empties both stores and clears the drop flag.
	a_run_clears: assert property (@(posedge clk) disable iff (!arst_n)
		flush_push |=> (stat_a.count == '0) && (stat_b.count == '0) && !dropped_q)
		else $error("stores not cleared after a run");
endmodule

// ===== design/pta_term_store.sv =====
// One term store: a memory whose lower half takes loaded terms and whose
// upper half receives the stably sorted copy, plus the rank-based sorter.
module pta_term_store (
	input  logic                  clk,
	input  logic                  arst_n,
	input  pta_pkg::store_ctrl_t  ctrl,
	input  pta_pkg::term_t        load_term,
	output pta_pkg::store_stat_t  stat,
	output pta_pkg::term_t        rd_term
);
	localparam int CW = pta_pkg::CNT_W;
	localparam int IW = pta_pkg::IDX_W;
	localparam int AW = pta_pkg::ADDR_W;

	typedef enum logic [2:0] {S_IDLE, S_KEY, S_LATCH, S_SCAN, S_WRITE} sort_state_t;

	sort_state_t          state_q;
	logic [CW-1:0]        count_q;
	logic [IW-1:0]        k_q;
	logic [IW-1:0]        cmp_idx_q;
	logic [IW-1:0]        rank_q;
	pta_pkg::term_t       key_q;
	pta_pkg::term_t       rdata_q;
	pta_pkg::term_t       mem [pta_pkg::MEM_DEPTH];

	logic [AW-1:0]        rd_addr;
	logic [AW-1:0]        wr_addr;
	pta_pkg::term_t       wr_data;
	logic                 wr_en;
	logic                 ranks_before;
	logic                 last_cmp;
	logic                 last_key;

	// An entry ranks before the key if its exponent is smaller, or equal and
	// it was loaded earlier; this keeps the sort stable.
	assign ranks_before = ($signed(rdata_q.expo) < $signed(key_q.expo)) ||
		((rdata_q.expo == key_q.expo) && (cmp_idx_q < k_q));
	assign last_cmp = (CW'(cmp_idx_q) + CW'(1)) == count_q;
	assign last_key = (CW'(k_q) + CW'(1)) == count_q;

	always_comb begin
		case (state_q)
			S_KEY:   rd_addr = {1'b0, k_q};
			S_LATCH: rd_addr = {1'b0, IW'(0)};
			S_SCAN:  rd_addr = {1'b0, cmp_idx_q + 1'b1};
			default: rd_addr = {1'b1, ctrl.rd_idx};
		endcase
	end

	always_comb begin
		if (state_q == S_WRITE) begin
			wr_en   = 1'b1;
			wr_addr = {1'b1, rank_q};
			wr_data = key_q;
		end else begin
			wr_en   = ctrl.load;
			wr_addr = {1'b0, count_q[IW-1:0]};
			wr_data = load_term;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			k_q       <= '0;
			cmp_idx_q <= '0;
			rank_q    <= '0;
			key_q     <= '0;
		end else begin
			if (ctrl.clear) begin
				count_q <= '0;
			end else if (ctrl.load) begin
				count_q <= count_q + 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					if (ctrl.sort_start && (count_q != '0)) begin
						k_q     <= '0;
						state_q <= S_KEY;
					end
				end
				S_KEY: begin
					state_q <= S_LATCH;
				end
				S_LATCH: begin
					key_q     <= rdata_q;
					cmp_idx_q <= '0;
					rank_q    <= '0;
					state_q   <= S_SCAN;
				end
				S_SCAN: begin
					rank_q <= rank_q + IW'(ranks_before);
					if (last_cmp) begin
						state_q <= S_WRITE;
					end else begin
						cmp_idx_q <= cmp_idx_q + 1'b1;
					end
				end
				S_WRITE: begin
					k_q <= k_q + 1'b1;
					if (last_key) begin
						state_q <= S_IDLE;
					end else begin
						state_q <= S_KEY;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign stat.count     = count_q;
	assign stat.sort_busy = (state_q != S_IDLE);
	assign rd_term        = rdata_q;
endmodule

// ===== tb/tb.sv =====
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int COEF_W    = pta_pkg::COEF_W;
	localparam int EXPO_W    = pta_pkg::EXPO_W;
	localparam int SUM_W     = pta_pkg::SUM_W;
	localparam int MAX_TERMS = pta_pkg::MAX_TERMS;

	// A list of terms in load order, one per polynomial.
	typedef pta_pkg::term_t term_list_t[$];

	// The block ignores mode 3 and the package has no name for it.
	localparam logic [1:0] MODE_IGNORED = 2'd3;

	localparam logic signed [COEF_W-1:0] COEF_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [COEF_W-1:0] COEF_MIN = 32'sh8000_0000;
	localparam logic signed [EXPO_W-1:0] EXPO_MAX = 16'sh7FFF;
	localparam logic signed [EXPO_W-1:0] EXPO_MIN = 16'sh8000;

	// Stop rules for the random part: load and run items, and result items predicted.
	localparam int RANDOM_ITEMS   = 25;
	localparam int RANDOM_RESULTS = 20;

	// A full run ranks 16 terms per store and then merges; DRAIN_CYCLES after the last
	// result gives any stray item time to show up.
	localparam int DRAIN_CYCLES = 40;
	localparam int CYCLE_LIMIT  = 200_000;

	logic clk = 1'b0;
	logic arst_n;

	pta_in_if  term_if();
	pta_out_if result_if();

	polynomial_term_merge_add_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.term   (term_if),
		.result (result_if)
	);

	always #5 clk = ~clk;

	// Shadow of the block: the two term stores in load order and the drop flag.
	pta_pkg::term_t   first_terms[$];
	pta_pkg::term_t   second_terms[$];
	bit               drop_seen;

	// Result items predicted but not yet seen on the output, oldest first.
	pta_pkg::result_t expected_terms[$];

	int mismatch_count    = 0;
	int cycle_count       = 0;
	int items_sent        = 0;
	int ignored_sent      = 0;
	int runs_sent         = 0;
	int results_predicted = 0;
	int results_checked   = 0;
	int burst_left        = 0;
	int stall_cycle       = 0;
	int stall_style       = 0;

	// Stable insertion sort by ascending exponent, so equal exponents keep load order.
	function automatic term_list_t sort_by_exponent(input term_list_t src);
		term_list_t     dst;
		pta_pkg::term_t key;
		int             j;
		dst = src;
		for (int i = 1; i < dst.size(); i++) begin
			key = dst[i];
			j = i;
			while (j > 0 && dst[j-1].expo > key.expo) begin
				dst[j] = dst[j-1];
				j--;
			end
			dst[j] = key;
		end
		return dst;
	endfunction

	function automatic pta_pkg::result_t make_result(input logic signed [SUM_W-1:0] coef,
			input logic signed [EXPO_W-1:0] expo, input logic has_term);
		pta_pkg::result_t r;
		r.sum_coefficient = coef;
		r.sum_exponent    = expo;
		r.term_valid      = has_term;
		r.last_term       = 1'b0;
		r.overflow        = drop_seen;
		return r;
	endfunction

	// Merge of the two sorted stores. Equal exponents are added and a zero sum is
	// dropped; once one side runs out, the rest of the other side is copied.
	task automatic predict_sum();
		term_list_t                a;
		term_list_t                b;
		pta_pkg::result_t          run_out[$];
		int                        i;
		int                        j;
		logic signed [SUM_W-1:0]   c;
		logic signed [EXPO_W-1:0]  e;
		a = sort_by_exponent(first_terms);
		b = sort_by_exponent(second_terms);
		i = 0;
		j = 0;
		while (i < a.size() || j < b.size()) begin
			if (i < a.size() && j < b.size() && a[i].expo == b[j].expo) begin
				c = $signed(a[i].coef) + $signed(b[j].coef);
				e = a[i].expo;
				i++;
				j++;
				if (c != 0) begin
					run_out = {run_out, make_result(c, e, 1'b1)};
				end
			end else if (i < a.size() && (j >= b.size() || a[i].expo < b[j].expo)) begin
				c = a[i].coef;
				run_out = {run_out, make_result(c, a[i].expo, 1'b1)};
				i++;
			end else begin
				c = b[j].coef;
				run_out = {run_out, make_result(c, b[j].expo, 1'b1)};
				j++;
			end
		end
		// Everything cancelled or nothing was loaded: one empty marker item.
		if (run_out.size() == 0) begin
			run_out = {run_out, make_result('0, '0, 1'b0)};
		end
		run_out[run_out.size()-1].last_term = 1'b1;
		expected_terms = {expected_terms, run_out};
		results_predicted += run_out.size();
		first_terms.delete();
		second_terms.delete();
		drop_seen = 1'b0;
	endtask

	task automatic predict_item(input logic [1:0] mode, input logic signed [COEF_W-1:0] coef,
			input logic signed [EXPO_W-1:0] expo);
		pta_pkg::term_t t;
		t.coef = coef;
		t.expo = expo;
		case (mode)
			pta_pkg::MODE_LOAD_FIRST: begin
				if (first_terms.size() < MAX_TERMS) first_terms = {first_terms, t};
				else drop_seen = 1'b1;
			end
			pta_pkg::MODE_LOAD_SECOND: begin
				if (second_terms.size() < MAX_TERMS) second_terms = {second_terms, t};
				else drop_seen = 1'b1;
			end
			pta_pkg::MODE_RUN: begin
				predict_sum();
			end
			default: begin
			end
		endcase
	endtask

	// Sends one item. The sender works in bursts; between bursts valid may drop for a
	// random gap. It returns at the clock edge that accepted the item, with valid
	// still high, so the next item can follow back to back.
	task automatic send_item(input logic [1:0] mode, input logic signed [COEF_W-1:0] coef,
			input logic signed [EXPO_W-1:0] expo);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 :
				$urandom_range(1, ($urandom_range(0, 7) == 0) ? 20 : 4);
			burst_left = $urandom_range(1, 24);
			if (gap > 0) begin
				term_if.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		term_if.valid       <= 1'b1;
		term_if.mode        <= mode;
		term_if.coefficient <= coef;
		term_if.exponent    <= expo;
		do @(posedge clk); while (!term_if.ready);
		predict_item(mode, coef, expo);
		if (mode == MODE_IGNORED) ignored_sent++;
		else items_sent++;
		if (mode == pta_pkg::MODE_RUN) runs_sent++;
	endtask

	function automatic int term_count();
		return ($urandom_range(0, 7) == 0) ? int'($urandom_range(7, MAX_TERMS)) :
			int'($urandom_range(0, 6));
	endfunction

	function automatic logic signed [COEF_W-1:0] random_coef();
		case ($urandom_range(0, 5))
			0: return COEF_W'(int'($urandom_range(0, 18)) - 9);
			1: return $urandom_range(0, 1) ? COEF_MAX : COEF_MIN;
			default: return $urandom;
		endcase
	endfunction

	// A new term for one side. Now and then it mirrors a term of the other side
	// with the coefficient negated, so the merge sees exact cancellation. Narrow
	// exponents cluster around a base to force plenty of equal exponents.
	function automatic pta_pkg::term_t next_term(input term_list_t other,
			input logic signed [EXPO_W-1:0] base, input bit narrow);
		pta_pkg::term_t t;
		int             k;
		if (other.size() > 0 && $urandom_range(0, 2) == 0) begin
			k = $urandom_range(0, other.size() - 1);
			t.coef = -other[k].coef;
			t.expo = other[k].expo;
		end else begin
			t.coef = random_coef();
			t.expo = narrow ? base + EXPO_W'($urandom_range(0, 6)) - EXPO_W'(3) :
				EXPO_W'($urandom);
		end
		return t;
	endfunction

	// Both stores empty: the run must give the single empty marker.
	task automatic test_empty_sum();
		send_item(pta_pkg::MODE_RUN, $urandom, EXPO_W'($urandom));
	endtask

	// Largest and smallest coefficients and exponents, so the widened sum reaches the low end
	// of its range and one below the high end, plus a term found on one side only.
	task automatic test_field_extremes();
		send_item(pta_pkg::MODE_LOAD_FIRST, COEF_MAX, EXPO_MAX);
		send_item(pta_pkg::MODE_LOAD_FIRST, COEF_MIN, EXPO_MIN);
		send_item(pta_pkg::MODE_LOAD_SECOND, COEF_MAX, EXPO_MAX);
		send_item(pta_pkg::MODE_LOAD_SECOND, COEF_MIN, EXPO_MIN);
		send_item(pta_pkg::MODE_LOAD_SECOND, -32'sd1, 16'sd0);
		send_item(pta_pkg::MODE_RUN, $urandom, EXPO_W'($urandom));
	endtask

	// Every pair cancels, so the sum is empty although both stores hold terms.
	task automatic test_cancellation();
		send_item(pta_pkg::MODE_LOAD_FIRST, 32'sd5, 16'sd3);
		send_item(pta_pkg::MODE_LOAD_FIRST, -32'sd7, -16'sd2);
		send_item(pta_pkg::MODE_LOAD_SECOND, -32'sd5, 16'sd3);
		send_item(pta_pkg::MODE_LOAD_SECOND, 32'sd7, -16'sd2);
		send_item(pta_pkg::MODE_RUN, $urandom, EXPO_W'($urandom));
	endtask

	// Two terms of the first polynomial share an exponent and are loaded out of
	// order; only the first of them pairs with the second polynomial, the other
	// passes through, and then the rest of the second side is copied.
	task automatic test_repeated_exponent();
		send_item(pta_pkg::MODE_LOAD_FIRST, 32'sd1, 16'sd2);
		send_item(pta_pkg::MODE_LOAD_FIRST, 32'sd7, 16'sd2);
		send_item(pta_pkg::MODE_LOAD_FIRST, 32'sd9, -16'sd4);
		send_item(pta_pkg::MODE_LOAD_SECOND, 32'sd3, 16'sd2);
		send_item(pta_pkg::MODE_LOAD_SECOND, 32'sd6, 16'sd10);
		send_item(pta_pkg::MODE_RUN, $urandom, EXPO_W'($urandom));
	endtask

	// A mode 3 item must neither load a term nor start a run.
	task automatic test_ignored_mode();
		send_item(MODE_IGNORED, $urandom, EXPO_W'($urandom));
		send_item(pta_pkg::MODE_LOAD_FIRST, 32'sd4, 16'sd1);
		send_item(pta_pkg::MODE_RUN, $urandom, EXPO_W'($urandom));
	endtask

	// Each store in turn is loaded past its capacity; the extra terms are dropped
	// and the run reports overflow on every one of its result items. The first
	// pass fills both stores, giving the longest possible run.
	task automatic test_capacity();
		term_list_t               none;
		pta_pkg::term_t           t;
		int                       n_target;
		int                       n_other;
		logic [1:0]               target;
		logic [1:0]               other;
		logic signed [EXPO_W-1:0] base;
		for (int pass = 0; pass < 2; pass++) begin
			target   = (pass == 0) ? pta_pkg::MODE_LOAD_FIRST : pta_pkg::MODE_LOAD_SECOND;
			other    = (pass == 0) ? pta_pkg::MODE_LOAD_SECOND : pta_pkg::MODE_LOAD_FIRST;
			n_target = MAX_TERMS + $urandom_range(1, 3);
			n_other  = (pass == 0) ? MAX_TERMS : $urandom_range(0, 4);
			base     = EXPO_W'($urandom);
			for (int k = 0; k < n_target; k++) begin
				t = next_term(none, base, 1'b1);
				send_item(target, t.coef, t.expo);
			end
			for (int k = 0; k < n_other; k++) begin
				t = next_term(none, base, 1'b1);
				send_item(other, t.coef, t.expo);
			end
			send_item(pta_pkg::MODE_RUN, $urandom, EXPO_W'($urandom));
		end
	endtask

	// Random well-formed sums: a random number of terms for each side, loaded in
	// random interleaving, then a run. Ignored items are mixed in as noise, and
	// empty or one-sided sums come up on their own.
	task automatic test_random_sums();
		term_list_t               first_loaded;
		term_list_t               second_loaded;
		pta_pkg::term_t           t;
		int                       start_items;
		int                       start_results;
		int                       n_first;
		int                       n_second;
		bit                       narrow;
		logic signed [EXPO_W-1:0] base;
		start_items   = items_sent;
		start_results = results_predicted;
		while (items_sent - start_items < RANDOM_ITEMS ||
				results_predicted - start_results < RANDOM_RESULTS) begin
			n_first  = term_count();
			n_second = term_count();
			narrow   = ($urandom_range(0, 3) != 0);
			base     = EXPO_W'($urandom);
			first_loaded.delete();
			second_loaded.delete();
			while (n_first + n_second > 0) begin
				if ($urandom_range(0, 11) == 0) begin
					send_item(MODE_IGNORED, $urandom, EXPO_W'($urandom));
				end
				if (n_second == 0 || (n_first > 0 && $urandom_range(0, 1) == 1)) begin
					t = next_term(second_loaded, base, narrow);
					first_loaded = {first_loaded, t};
					n_first--;
					send_item(pta_pkg::MODE_LOAD_FIRST, t.coef, t.expo);
				end else begin
					t = next_term(first_loaded, base, narrow);
					second_loaded = {second_loaded, t};
					n_second--;
					send_item(pta_pkg::MODE_LOAD_SECOND, t.coef, t.expo);
				end
			end
			send_item(pta_pkg::MODE_RUN, $urandom, EXPO_W'($urandom));
		end
	endtask

	// The receiver draws a new stall style whenever stall_cycle is a multiple of 64: always ready,
	// ready when stall_cycle is a multiple of 3, random, or ready while stall_cycle mod 16 is below 10.
	always @(posedge clk) begin
		if (stall_cycle % 64 == 0) stall_style = $urandom_range(0, 3);
		case (stall_style)
			0: result_if.ready <= 1'b1;
			1: result_if.ready <= (stall_cycle % 3 == 0);
			2: result_if.ready <= 1'($urandom_range(0, 1));
			default: result_if.ready <= (stall_cycle % 16 < 10);
		endcase
		stall_cycle++;
	end

	// Every accepted result item is compared with the oldest prediction.
	always @(posedge clk) begin
		pta_pkg::result_t want;
		if (arst_n && result_if.valid && result_if.ready) begin
			results_checked++;
			if (expected_terms.size() == 0) begin
				$error("result item with nothing expected: sum_coefficient %0d sum_exponent %0d",
					result_if.sum_coefficient, result_if.sum_exponent);
				mismatch_count++;
			end else begin
				want = expected_terms.pop_front();
				if (result_if.sum_coefficient !== want.sum_coefficient) begin
					$error("sum_coefficient: expected %0d, actual %0d",
						want.sum_coefficient, result_if.sum_coefficient);
					mismatch_count++;
				end
				if (result_if.sum_exponent !== want.sum_exponent) begin
					$error("sum_exponent: expected %0d, actual %0d",
						want.sum_exponent, result_if.sum_exponent);
					mismatch_count++;
				end
				if (result_if.term_valid !== want.term_valid) begin
					$error("term_valid: expected %0b, actual %0b",
						want.term_valid, result_if.term_valid);
					mismatch_count++;
				end
				if (result_if.last_term !== want.last_term) begin
					$error("last_term: expected %0b, actual %0b",
						want.last_term, result_if.last_term);
					mismatch_count++;
				end
				if (result_if.overflow !== want.overflow) begin
					$error("overflow: expected %0b, actual %0b",
						want.overflow, result_if.overflow);
					mismatch_count++;
				end
			end
		end
	end

	// Watchdog: a hung handshake ends the run here.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("polynomial_term_merge_add_unit test failed");
			$finish;
		end
	end

	initial begin
		arst_n              <= 1'b0;
		term_if.valid       <= 1'b0;
		term_if.mode        <= pta_pkg::MODE_LOAD_FIRST;
		term_if.coefficient <= '0;
		term_if.exponent    <= '0;
		drop_seen = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_sum();
		test_field_extremes();
		test_cancellation();
		test_repeated_exponent();
		test_ignored_mode();
		test_capacity();
		test_random_sums();

		// All stimulus is in; let the last run drain and catch any stray item.
		term_if.valid <= 1'b0;
		while (expected_terms.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d load and run items (%0d runs) and %0d ignored items;",
			items_sent, runs_sent, ignored_sent);
		$display("checked %0d result items, %0d mismatches.", results_checked, mismatch_count);
		if (mismatch_count == 0) begin
			$display("polynomial_term_merge_add_unit test passed");
		end else begin
			$display("polynomial_term_merge_add_unit test failed");
		end
		$finish;
	end

endmodule
